### sv/itoa_pkg.sv
// shared types, constants and tables for the signed integer to decimal text unit
`default_nettype none
package itoa_pkg;

  localparam int NUM_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 4;
  localparam int THR_W       = NUM_W + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_POS     = 10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } back_state_t;

  function automatic logic [NUM_W-1:0] pow10(input logic [POS_W-1:0] p);
    logic [NUM_W-1:0] v;
    case (p)
      4'd0:    v = 32'd1;
      4'd1:    v = 32'd10;
      4'd2:    v = 32'd100;
      4'd3:    v = 32'd1000;
      4'd4:    v = 32'd10000;
      4'd5:    v = 32'd100000;
      4'd6:    v = 32'd1000000;
      4'd7:    v = 32'd10000000;
      4'd8:    v = 32'd100000000;
      4'd9:    v = 32'd1000000000;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/itoa_front.sv
// front part: takes numbers, forms sign, magnitude and leading digit position
`default_nettype none
module itoa_front (
  input  logic                       in_valid,
  input  logic [itoa_pkg::NUM_W-1:0] in_number,
  output logic                       in_stall,
  input  logic                       q_full,
  output logic                       q_push,
  output itoa_pkg::item_t            q_wdata
);
  import itoa_pkg::*;

  logic             neg;
  logic [NUM_W-1:0] mag;
  logic [POS_W-1:0] pos;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    neg = in_number[NUM_W-1];
    mag = neg ? (~in_number + {{(NUM_W-1){1'b0}}, 1'b1}) : in_number;
    pos = '0;
    for (int p = 1; p < NUM_POS; p++) begin
      if (mag >= pow10(POS_W'(p))) begin
        pos = pos + {{(POS_W-1){1'b0}}, 1'b1};
      end
    end
  end

  assign q_wdata = '{neg: neg, mag: mag, pos: pos};

endmodule
`default_nettype wire

### sv/itoa_queue.sv
// small item queue between the front and back parts
`default_nettype none
module itoa_queue #(
  parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itoa_pkg::item_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output itoa_pkg::item_t rdata
);
  import itoa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + {{(AW-1){1'b0}}, 1'b1};
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + {{(AW-1){1'b0}}, 1'b1};
    end
    if (push && !pop) begin
      count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
    end else if (pop && !push) begin
      count_nxt = count_r - {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### sv/itoa_back.sv
// back part: emits sign and decimal digits, most significant first
`default_nettype none
module itoa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  itoa_pkg::item_t             q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [itoa_pkg::CHAR_W-1:0] out_character,
  output logic                        out_last,
  input  logic                        out_stall
);
  import itoa_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [NUM_W-1:0]  mag_r, mag_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              adv;
  logic [THR_W-1:0]  thr [NUM_POS];
  logic [POS_W-1:0]  dig;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = (state_r == BK_IDLE) && q_valid;

  // digit of the current position by compare against its multiples
  always_comb begin
    dig    = '0;
    thr[0] = '0;
    for (int k = 1; k < NUM_POS; k++) begin
      thr[k] = {3'b000, pow10(pos_r)} * THR_W'(k);
    end
    for (int k = 1; k < NUM_POS; k++) begin
      if ({3'b000, mag_r} >= thr[k]) begin
        dig = dig + {{(POS_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = q_rdata.neg ? BK_SIGN : BK_DIGIT;
        end
      end
      BK_SIGN: begin
        if (adv) begin
          state_nxt = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (adv && pos_r == '0) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    mag_nxt       = mag_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          mag_nxt = q_rdata.mag;
          pos_nxt = q_rdata.pos;
        end
      end
      BK_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      BK_DIGIT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {{(CHAR_W-POS_W){1'b0}}, dig};
          out_last_nxt  = (pos_r == '0);
          mag_nxt       = mag_r - thr[dig][NUM_W-1:0];
          pos_nxt       = pos_r - {{(POS_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

### sv/signed_int_to_decimal_ascii_unit.sv
// top level of the signed 32-bit integer to decimal text unit
// Each accepted number comes out as its decimal text, one ASCII character per
// output item, most significant first, with a leading '-' for negative values
// and out_last set on the final character. The front part is combinational
// and parks each number in a queue of QUEUE_DEPTH items; the back part then
// loads it in its idle state and emits one character per cycle while
// out_stall is low, so this emitter sets the sustained rate. Numbers are
// accepted while the queue has room.
`default_nettype none
module signed_int_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [itoa_pkg::NUM_W-1:0]  in_number,
  output logic                        in_stall,
  output logic                        out_valid,
  output logic [itoa_pkg::CHAR_W-1:0] out_character,
  output logic                        out_last,
  input  logic                        out_stall
);
  import itoa_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  item_t q_wdata;
  item_t q_rdata;

  itoa_front u_front (
    .in_valid  (in_valid),
    .in_number (in_number),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  itoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_stall     (out_stall)
  );

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == ASCII_MINUS |-> !out_last)
    else $error("minus sign marked as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == ASCII_MINUS) ||
                  (out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + 8'd9))
    else $error("output character is neither sign nor digit");

  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !in_stall)
    else $error("input stalled while queue is empty");

endmodule
`default_nettype wire
